>>> src/sab_pkg.sv
// ----------------------------------------------------------------------------
// Suffix array builder package
// Shared constants, command and status codes, and the control and status
// bundles that join the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int unsigned MAX_LEN = 256;
  localparam int unsigned LEVELS  = 10;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 9;
  localparam int unsigned STS_W = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STS_W-1:0] ST_BADPOS  = 2'd2;
  localparam logic [STS_W-1:0] ST_UNBUILT = 2'd3;

  // Operations requested by the sequencer for the current cycle.
  typedef struct packed {
    logic accept;
    logic copy_run;
    logic lvl_init;
    logic lvl_start;
    logic ord_start;
    logic fetch;
    logic wait_i;
    logic scan;
    logic write_r;
    logic lvl_next;
    logic finish_build;
    logic q_issue;
    logic q_cmp;
    logic load_out;
  } dp_op_t;

  // Conditions reported back by the datapath.
  typedef struct packed {
    logic copy_done;
    logic lvl_more;
    logic i_done;
    logic ord_mode;
    logic scan_done;
    logic q_more;
    logic qry_go;
  } dp_sts_t;

endpackage

>>> src/sab_ctrl.sv
// ----------------------------------------------------------------------------
// Suffix array builder sequencer
// State machine that steps the datapath through commands, build rounds,
// the final ordering pass and prefix queries.
// ----------------------------------------------------------------------------
module sab_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sab_pkg::CMD_W-1:0]     in_command_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  sab_pkg::dp_sts_t              sts_i,
  output sab_pkg::dp_op_t               op_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_COPY   = 4'd1;
  localparam logic [3:0] S_LCHK   = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_WAIT   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_QISSUE = 4'd7;
  localparam logic [3:0] S_QCMP   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    op_o    = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o.accept = 1'b1;
          unique case (in_command_i)
            sab_pkg::CMD_BUILD: state_d = S_COPY;
            sab_pkg::CMD_QUERY: state_d = sts_i.qry_go ? S_QISSUE : S_DONE;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_COPY: begin
        op_o.copy_run = 1'b1;
        if (sts_i.copy_done) begin
          op_o.lvl_init = 1'b1;
          state_d       = S_LCHK;
        end
      end
      S_LCHK: begin
        if (sts_i.lvl_more) begin
          op_o.lvl_start = 1'b1;
        end else begin
          op_o.ord_start = 1'b1;
        end
        state_d = S_FETCH;
      end
      S_FETCH: begin
        if (sts_i.i_done) begin
          if (sts_i.ord_mode) begin
            op_o.finish_build = 1'b1;
            state_d           = S_DONE;
          end else begin
            op_o.lvl_next = 1'b1;
            state_d       = S_LCHK;
          end
        end else begin
          op_o.fetch = 1'b1;
          state_d    = S_WAIT;
        end
      end
      S_WAIT: begin
        op_o.wait_i = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        op_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        op_o.write_r = 1'b1;
        state_d      = S_FETCH;
      end
      S_QISSUE: begin
        if (sts_i.q_more) begin
          op_o.q_issue = 1'b1;
          state_d      = S_QCMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_QCMP: begin
        op_o.q_cmp = 1'b1;
        state_d    = S_QISSUE;
      end
      S_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          op_o.load_out = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = op_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/sab_dp.sv
// ----------------------------------------------------------------------------
// Suffix array builder datapath
// Text, rank level and sorted start memories, the scan counters, the pair
// comparator and the result register.
// ----------------------------------------------------------------------------
module sab_dp #(
  parameter int unsigned MAX_LEN = sab_pkg::MAX_LEN,
  parameter int unsigned LEVELS  = sab_pkg::LEVELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sab_pkg::dp_op_t               op_i,
  output sab_pkg::dp_sts_t              sts_o,
  input  logic [sab_pkg::CMD_W-1:0]     in_command_i,
  input  logic [sab_pkg::SYM_W-1:0]     in_symbol_i,
  input  logic [sab_pkg::POS_W-1:0]     in_position_i,
  input  logic [sab_pkg::POS_W-1:0]     in_other_position_i,
  output logic [sab_pkg::VAL_W-1:0]     out_value_o,
  output logic [sab_pkg::STS_W-1:0]     out_status_o
);

  localparam int unsigned IW  = $clog2(MAX_LEN);
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned RW  = (IW > 8) ? IW : 8;
  localparam int unsigned LVW = $clog2(LEVELS);
  localparam int unsigned LCW = $clog2(LEVELS + 1);
  localparam int unsigned SPW = LEVELS;
  localparam int unsigned SW  = ((LW > SPW) ? LW : SPW) + 1;
  localparam int unsigned PCW = (LW > 8) ? LW : 8;
  localparam int unsigned SLW = ((RW > LW) ? RW : LW) + 1;

  logic [7:0]    text_mem [MAX_LEN];
  logic [RW-1:0] rank_mem [LEVELS][MAX_LEN];
  logic [IW-1:0] sort_mem [MAX_LEN];

  logic [LW-1:0]  len_q, i_q, j_q, cnt_q, a_q, b_q, ans_q;
  logic [LCW-1:0] lvl_cnt_q, steps_q, kl_q;
  logic           built_q, full_q, ord_q, bin_q, sv_q, cp_v_q;
  logic [2:0]     cmd_q;
  logic [7:0]     pos_q, oth_q, txt_rd_q;
  logic [SPW-1:0] span_q;
  logic [RW-1:0]  fi_q, rda_q, rdb_q;
  logic [RW:0]    si_q;
  logic [IW-1:0]  cp_idx_q, sort_rd_q;
  logic [sab_pkg::VAL_W-1:0] out_value_q;
  logic [sab_pkg::STS_W-1:0] out_status_q;

  logic [SW-1:0]  n_s, i_plus, j_plus;
  logic [LVW-1:0] lvl_rd, k_idx, ra_lvl;
  logic [IW-1:0]  ra_idx, rb_idx;
  logic [LW-1:0]  jlim, k_step;
  logic [RW:0]    sj;
  logic           hit;
  logic [SLW-1:0] slot;
  logic [PCW-1:0] pos_w, oth_w, len_w, pq_w, oq_w;
  logic           is_append;
  logic [sab_pkg::VAL_W-1:0] fin_value;
  logic [sab_pkg::STS_W-1:0] fin_status;

  assign n_s    = SW'(len_q);
  assign i_plus = SW'(i_q) + SW'(span_q);
  assign j_plus = SW'(j_q) + SW'(span_q);
  assign lvl_rd = LVW'(steps_q - LCW'(1));
  assign k_idx  = LVW'(kl_q - LCW'(1));
  assign k_step = LW'(1) << k_idx;
  assign jlim   = ord_q ? i_q : len_q;
  assign pos_w  = PCW'(in_position_i);
  assign oth_w  = PCW'(in_other_position_i);
  assign len_w  = PCW'(len_q);
  assign pq_w   = PCW'(pos_q);
  assign oq_w   = PCW'(oth_q);
  assign is_append = (in_command_i == sab_pkg::CMD_APPEND);

  // Second key is zero past the end of the string, else rank plus one.
  assign sj   = bin_q ? ({1'b0, rdb_q} + (RW+1)'(1)) : '0;
  assign hit  = ord_q ? (rda_q == fi_q)
                      : ((rda_q < fi_q) || ((rda_q == fi_q) && (sj < si_q)));
  assign slot = SLW'(fi_q) + SLW'(cnt_q);

  always_comb begin
    ra_lvl = lvl_rd;
    ra_idx = IW'(j_q);
    rb_idx = IW'(j_plus);
    if (op_i.fetch) begin
      ra_idx = IW'(i_q);
      rb_idx = IW'(i_plus);
    end
    if (op_i.q_issue) begin
      ra_lvl = k_idx;
      ra_idx = IW'(a_q);
      rb_idx = IW'(b_q);
    end
  end

  assign sts_o.copy_done = (i_q >= len_q) && !cp_v_q;
  assign sts_o.lvl_more  = ((SW'(span_q) >> 1) < n_s) && (steps_q < LCW'(LEVELS));
  assign sts_o.i_done    = (i_q >= len_q);
  assign sts_o.ord_mode  = ord_q;
  assign sts_o.scan_done = (j_q >= jlim) && !sv_q;
  assign sts_o.q_more    = (kl_q != '0) && (a_q < len_q) && (b_q < len_q);
  assign sts_o.qry_go    = built_q && (pos_w < len_w) && (oth_w < len_w) && (pos_w != oth_w);

  // Memories.
  always_ff @(posedge clk_i) begin
    rda_q <= rank_mem[ra_lvl][ra_idx];
    rdb_q <= rank_mem[ra_lvl][rb_idx];
    if (cp_v_q) begin
      rank_mem[0][cp_idx_q] <= RW'(txt_rd_q);
    end else if (op_i.write_r && !ord_q) begin
      rank_mem[LVW'(steps_q)][IW'(i_q)] <= RW'(cnt_q);
    end
    if (op_i.write_r && ord_q && (slot < SLW'(MAX_LEN))) begin
      sort_mem[IW'(slot)] <= IW'(i_q);
    end
    if (op_i.accept && is_append && (len_q < LW'(MAX_LEN))) begin
      text_mem[IW'(len_q)] <= in_symbol_i;
    end
    if (op_i.copy_run) begin
      txt_rd_q <= text_mem[IW'(i_q)];
    end
    if (op_i.accept) begin
      sort_rd_q <= sort_mem[IW'(in_position_i)];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      lvl_cnt_q <= '0;
      built_q   <= 1'b0;
      cp_v_q    <= 1'b0;
      sv_q      <= 1'b0;
    end else begin
      if (op_i.accept) begin
        if (is_append && (len_q < LW'(MAX_LEN))) begin
          len_q   <= len_q + LW'(1);
          built_q <= 1'b0;
        end
        if (in_command_i == sab_pkg::CMD_CLEAR) begin
          len_q     <= '0;
          lvl_cnt_q <= '0;
          built_q   <= 1'b0;
        end
      end
      if (op_i.copy_run) begin
        cp_v_q <= (i_q < len_q);
      end
      if (op_i.scan) begin
        sv_q <= (j_q < jlim);
      end
      if (op_i.finish_build) begin
        lvl_cnt_q <= steps_q;
        built_q   <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (op_i.accept) begin
      cmd_q  <= in_command_i;
      pos_q  <= in_position_i;
      oth_q  <= in_other_position_i;
      full_q <= (len_q >= LW'(MAX_LEN));
      a_q    <= LW'(in_position_i);
      b_q    <= LW'(in_other_position_i);
      kl_q   <= lvl_cnt_q;
      ans_q  <= '0;
      i_q    <= '0;
    end
    if (op_i.copy_run && (i_q < len_q)) begin
      cp_idx_q <= IW'(i_q);
      i_q      <= i_q + LW'(1);
    end
    if (op_i.lvl_init) begin
      steps_q <= LCW'(1);
      span_q  <= SPW'(1);
    end
    if (op_i.lvl_start || op_i.ord_start) begin
      ord_q <= op_i.ord_start;
      i_q   <= '0;
    end
    if (op_i.lvl_next) begin
      steps_q <= steps_q + LCW'(1);
      span_q  <= span_q << 1;
    end
    if (op_i.fetch) begin
      j_q   <= '0;
      cnt_q <= '0;
      bin_q <= (i_plus < n_s);
    end
    if (op_i.wait_i) begin
      fi_q <= rda_q;
      si_q <= bin_q ? ({1'b0, rdb_q} + (RW+1)'(1)) : '0;
    end
    if (op_i.scan) begin
      if (j_q < jlim) begin
        bin_q <= (j_plus < n_s);
        j_q   <= j_q + LW'(1);
      end
      if (sv_q && hit) begin
        cnt_q <= cnt_q + LW'(1);
      end
    end
    if (op_i.write_r) begin
      i_q <= i_q + LW'(1);
    end
    if (op_i.q_cmp) begin
      if (rda_q == rdb_q) begin
        a_q   <= a_q + k_step;
        b_q   <= b_q + k_step;
        ans_q <= ans_q + k_step;
      end
      kl_q <= kl_q - LCW'(1);
    end
    if (op_i.load_out) begin
      out_value_q  <= fin_value;
      out_status_q <= fin_status;
    end
  end

  always_comb begin
    fin_value  = '0;
    fin_status = sab_pkg::ST_OK;
    case (cmd_q)
      sab_pkg::CMD_APPEND: begin
        fin_value  = sab_pkg::VAL_W'(len_q);
        fin_status = full_q ? sab_pkg::ST_FULL : sab_pkg::ST_OK;
      end
      sab_pkg::CMD_BUILD: fin_value = sab_pkg::VAL_W'(len_q);
      sab_pkg::CMD_READ: begin
        if (!built_q) begin
          fin_status = sab_pkg::ST_UNBUILT;
        end else if (pq_w >= len_w) begin
          fin_status = sab_pkg::ST_BADPOS;
        end else begin
          fin_value = sab_pkg::VAL_W'(sort_rd_q);
        end
      end
      sab_pkg::CMD_QUERY: begin
        if (!built_q) begin
          fin_status = sab_pkg::ST_UNBUILT;
        end else if ((pq_w >= len_w) || (oq_w >= len_w)) begin
          fin_status = sab_pkg::ST_BADPOS;
        end else if (pq_w == oq_w) begin
          fin_value = sab_pkg::VAL_W'(len_w - pq_w);
        end else begin
          fin_value = sab_pkg::VAL_W'(ans_q);
        end
      end
      default: fin_value = '0;
    endcase
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

>>> src/suffix_array_builder_core.sv
// ----------------------------------------------------------------------------
// Suffix array builder core
// Loads a string byte by byte, ranks its suffixes by prefix doubling and
// answers sorted entry reads and longest common prefix queries.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o  | command, symbol, position,
//           |           |                          | other_position
//   out     | output    | out_valid_o / out_stall_i| value, status
//
// Append, clear, read and unknown commands pass from transfer straight to the
// result state. A query issues a rank read and a compare per stored rank level visited.
// A build of n bytes copies the string, then runs R doubling rounds and a final
// ordering pass, each a scan by the single pair comparator that walks the rank
// memory one entry per cycle. Reset clears the length, level count, built flag,
// sequencer state, output valid and copy and scan valid flags; the memories need
// no clearing pass. A finished result waits in the output register while the next command is taken in.
module suffix_array_builder_core #(
  parameter int unsigned MAX_LEN = sab_pkg::MAX_LEN,
  parameter int unsigned LEVELS  = sab_pkg::LEVELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sab_pkg::CMD_W-1:0]     in_command_i,
  input  logic [sab_pkg::SYM_W-1:0]     in_symbol_i,
  input  logic [sab_pkg::POS_W-1:0]     in_position_i,
  input  logic [sab_pkg::POS_W-1:0]     in_other_position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sab_pkg::VAL_W-1:0]     out_value_o,
  output logic [sab_pkg::STS_W-1:0]     out_status_o
);

  // The sequencer issues one bundle of operations per cycle; the datapath
  // answers with the loop conditions it needs to pick the next state.
  sab_pkg::dp_op_t  op;
  sab_pkg::dp_sts_t sts;

  sab_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_command_i (in_command_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .op_o         (op)
  );

  // The datapath holds every memory, so the string, all rank levels and the
  // sorted starts stay there between commands.
  sab_dp #(
    .MAX_LEN (MAX_LEN),
    .LEVELS  (LEVELS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .op_i                (op),
    .sts_o               (sts),
    .in_command_i        (in_command_i),
    .in_symbol_i         (in_symbol_i),
    .in_position_i       (in_position_i),
    .in_other_position_i (in_other_position_i),
    .out_value_o         (out_value_o),
    .out_status_o        (out_status_o)
  );

`ifndef SYNTHESIS
  // A transfer always leaves the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A full string reports its length, which is the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == sab_pkg::ST_FULL)
      |-> out_value_o == sab_pkg::VAL_W'(MAX_LEN))
    else $error("full status with wrong length");

  // Position and build errors carry a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_status_o == sab_pkg::ST_BADPOS) ||
                    (out_status_o == sab_pkg::ST_UNBUILT))
      |-> out_value_o == '0)
    else $error("error result with nonzero value");

  // A new result only appears after the block has been busy with a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a command in progress");
`endif

endmodule
